// ----- sv/dvg_pkg.sv -----
package dvg_pkg;

    // quotient bits produced by the divider chain, one per stage
    localparam int DIV_STEPS = 16;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int COLOR_W = 8;
    localparam int COORD_W = 10;
    localparam int OFFSET_W = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOP_RED      = 3'd0,
        CFG_TOP_GREEN    = 3'd1,
        CFG_TOP_BLUE     = 3'd2,
        CFG_BOTTOM_RED   = 3'd3,
        CFG_BOTTOM_GREEN = 3'd4,
        CFG_BOTTOM_BLUE  = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } cfg_reg_t;

    localparam logic [15:0] HASH_X = 16'hF45D;   // low half of 73856093
    localparam logic [15:0] HASH_Y = 16'h409F;   // low half of 19349663
    localparam logic [15:0] HASH_K = 16'h79B9;   // low half of 0x9E3779B9

    localparam logic [3:0] BAYER_MAP [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    localparam longint DIT_DEN = 320;
    localparam longint NOI_RB_DEN = 2550;
    localparam longint NOI_G_DEN = 25500;
    localparam longint VIG_STRENGTH = 7864;

    // sideband that rides along the divider chain
    typedef struct packed {
        logic       t_sat;
        logic       t_zero;
        logic       q_sat;
        logic       q_zero;
        logic [7:0] noise;
        logic [3:0] bayer;
    } side_t;

    function automatic longint qpow(input longint v, input int n);
        longint p;
        p = v;
        for (int i = 1; i < n; i++) begin
            p = (p * v) >> 16;
        end
        return p;
    endfunction

    // vignette gain in q1.16 for table entry q of a 2^bits table
    function automatic longint vignette_entry(input int q, input int bits);
        longint m;
        longint lo;
        longint hi;
        longint mid;
        longint f;
        longint target;
        longint e;
        m = (longint'(1) <<< bits) - 1;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * m <= longint'(q) * 65536) lo = mid;
            else hi = mid - 1;
        end
        f = lo;
        target = qpow(f, 4);
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (qpow(mid, 5) <= target) lo = mid;
            else hi = mid - 1;
        end
        e = (f * lo) >> 16;
        return 65536 - ((e * VIG_STRENGTH) >> 16);
    endfunction

    // rounded to nearest, halves toward +inf
    function automatic longint dither_rb(input int b);
        longint a;
        a = 2 * (longint'(2 * b - 15) * 9728) + DIT_DEN;
        return (a >= 0) ? a / (2 * DIT_DEN) : -((-a + 2 * DIT_DEN - 1) / (2 * DIT_DEN));
    endfunction

    function automatic longint dither_g(input int b);
        longint a;
        a = 2 * (longint'(2 * b - 15) * 4864) + DIT_DEN;
        return (a >= 0) ? a / (2 * DIT_DEN) : -((-a + 2 * DIT_DEN - 1) / (2 * DIT_DEN));
    endfunction

    function automatic longint noise_rb(input int n);
        longint a;
        a = 2 * (longint'(2 * n - 255) * 768) + NOI_RB_DEN;
        return (a >= 0) ? a / (2 * NOI_RB_DEN)
                        : -((-a + 2 * NOI_RB_DEN - 1) / (2 * NOI_RB_DEN));
    endfunction

    function automatic longint noise_g(input int n);
        longint a;
        a = 2 * (longint'(2 * n - 255) * 4608) + NOI_G_DEN;
        return (a >= 0) ? a / (2 * NOI_G_DEN)
                        : -((-a + 2 * NOI_G_DEN - 1) / (2 * NOI_G_DEN));
    endfunction

endpackage

// ----- sv/dvg_coord_if.sv -----
interface dvg_coord_if;
    logic                        valid;
    logic                        ready;
    logic [dvg_pkg::COORD_W-1:0] pixel_x;
    logic [dvg_pkg::COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ----- sv/dvg_color_if.sv -----
interface dvg_color_if;
    logic                        valid;
    logic                        ready;
    logic [15:0]                 pixel_rgb565;
    logic [dvg_pkg::COLOR_W-1:0] red_level;
    logic [dvg_pkg::COLOR_W-1:0] green_level;
    logic [dvg_pkg::COLOR_W-1:0] blue_level;

    modport source (output valid, output pixel_rgb565, output red_level,
                    output green_level, output blue_level, input ready);
    modport sink (input valid, input pixel_rgb565, input red_level,
                  input green_level, input blue_level, output ready);
endinterface

// ----- sv/dvg_div_stage.sv -----
module dvg_div_stage #(
    parameter int RW = 10
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [RW-1:0]                   divisor,
    input  logic [RW-1:0]                   rem_in,
    input  logic [dvg_pkg::DIV_STEPS-1:0]   nq_in,
    output logic [RW-1:0]                   rem_reg,
    output logic [dvg_pkg::DIV_STEPS-1:0]   nq_reg
);

    logic [RW:0]                     trial;
    logic [RW:0]                     diff;
    logic                            ge;
    logic [RW-1:0]                   rem_next;
    logic [dvg_pkg::DIV_STEPS-1:0]   nq_next;

    // numerator bits leave the top of nq while quotient bits enter the bottom
    always_comb
    begin
        trial = {rem_in, nq_in[dvg_pkg::DIV_STEPS-1]};
        diff = trial - {1'b0, divisor};
        ge = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
        nq_next = {nq_in[dvg_pkg::DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg <= nq_next;
        end
    end

endmodule

// ----- sv/dithered_vignette_gradient_pixel.sv -----
// background pixel generator: one (pixel_x, pixel_y) request in, one rgb565 pixel
// out, one pixel per clock sustained while the output accepts. a front setup
// stage feeds the two 16-stage restoring dividers (vertical blend weight
// and vignette table index) that run side by side, one quotient bit per stage,
// followed by select, blend, vignette scale and clamp stages. the whole
// pipeline holds on output backpressure. configuration is a plain write port and
// may only be written while no request is in flight; colors reset to black, width
// to 256 and height to 192.
module dithered_vignette_gradient_pixel #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int VIGNETTE_TABLE_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dvg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dvg_pkg::CFG_DATA_W-1:0]      cfg_data,
    dvg_coord_if.sink                           coord,
    dvg_color_if.source                         color
);

    localparam int STEPS = dvg_pkg::DIV_STEPS;
    localparam int WW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int WLW = WW + 1;
    localparam int HLW = HW + 1;
    localparam int DW = (WW > dvg_pkg::COORD_W + 1) ? WW : dvg_pkg::COORD_W + 1;
    localparam int YW = (HW > dvg_pkg::COORD_W) ? HW : dvg_pkg::COORD_W;
    localparam int PW = WW + STEPS;
    localparam int B = VIGNETTE_TABLE_BITS;
    localparam int VTAB = 1 << B;
    localparam int OW = dvg_pkg::OFFSET_W;

    // configuration registers
    logic [7:0]  top_reg [3];
    logic [7:0]  bot_reg [3];
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                top_reg[c] <= '0;
                bot_reg[c] <= '0;
            end
            width_reg <= 11'd256;
            height_reg <= 11'd192;
        end
        else if (cfg_write)
        begin
            unique case (dvg_pkg::cfg_reg_t'(cfg_index))
                dvg_pkg::CFG_TOP_RED:      top_reg[0] <= cfg_data[7:0];
                dvg_pkg::CFG_TOP_GREEN:    top_reg[1] <= cfg_data[7:0];
                dvg_pkg::CFG_TOP_BLUE:     top_reg[2] <= cfg_data[7:0];
                dvg_pkg::CFG_BOTTOM_RED:   bot_reg[0] <= cfg_data[7:0];
                dvg_pkg::CFG_BOTTOM_GREEN: bot_reg[1] <= cfg_data[7:0];
                dvg_pkg::CFG_BOTTOM_BLUE:  bot_reg[2] <= cfg_data[7:0];
                dvg_pkg::CFG_IMAGE_WIDTH:  width_reg <= cfg_data;
                dvg_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // constant tables, evaluated at elaboration
    logic [16:0]          vig_rom [VTAB];
    logic signed [OW-1:0] dit_rb_rom [16];
    logic signed [OW-1:0] dit_g_rom [16];
    logic signed [OW-1:0] noi_rb_rom [256];
    logic signed [OW-1:0] noi_g_rom [256];

    for (genvar gi = 0; gi < VTAB; gi++)
    begin : g_vig
        localparam logic [16:0] Entry = 17'(dvg_pkg::vignette_entry(gi, B));
        assign vig_rom[gi] = Entry;
    end

    // indexed by position in the 4x4 tile, holds the offset of its bayer level
    for (genvar gi = 0; gi < 16; gi++)
    begin : g_dit
        localparam logic [OW-1:0] Rb = OW'(dvg_pkg::dither_rb(int'(dvg_pkg::BAYER_MAP[gi])));
        localparam logic [OW-1:0] Gr = OW'(dvg_pkg::dither_g(int'(dvg_pkg::BAYER_MAP[gi])));
        assign dit_rb_rom[gi] = Rb;
        assign dit_g_rom[gi] = Gr;
    end

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_noi
        localparam logic [OW-1:0] Rb = OW'(dvg_pkg::noise_rb(gi));
        localparam logic [OW-1:0] Gr = OW'(dvg_pkg::noise_g(gi));
        assign noi_rb_rom[gi] = Rb;
        assign noi_g_rom[gi] = Gr;
    end

    // whole pipeline moves together, held while a finished pixel waits
    logic adv;
    logic out_valid_reg;

    assign adv = !out_valid_reg || color.ready;
    assign coord.ready = adv;

    // front stage: span and distance setup, hash and bayer index
    logic [WLW-1:0] w_lim;
    logic [HLW-1:0] h_lim;
    logic           w_gt1;
    logic           h_gt1;
    logic [WW-1:0]  span;
    logic [HW-1:0]  hdiv;
    logic [DW-1:0]  two_x;
    logic [DW-1:0]  span_d;
    logic [DW-1:0]  dx_abs;
    logic [PW-1:0]  num_q;
    logic [15:0]    hash;
    dvg_pkg::side_t side_next;

    always_comb
    begin
        if (32'(width_reg) > 32'(MAX_WIDTH)) w_lim = WLW'(MAX_WIDTH);
        else w_lim = WLW'(width_reg);
        if (32'(height_reg) > 32'(MAX_HEIGHT)) h_lim = HLW'(MAX_HEIGHT);
        else h_lim = HLW'(height_reg);
        w_gt1 = (w_lim > WLW'(1));
        h_gt1 = (h_lim > HLW'(1));
        span = WW'(w_lim - WLW'(1));
        hdiv = HW'(h_lim - HLW'(1));

        two_x = DW'({coord.pixel_x, 1'b0});
        span_d = DW'(span);
        dx_abs = (two_x > span_d) ? two_x - span_d : span_d - two_x;
        // dx_abs * (2^B - 1) + span / 2, only meaningful below saturation
        num_q = (PW'(dx_abs) << B) - PW'(dx_abs) + PW'(span >> 1);

        hash = 16'(coord.pixel_x * dvg_pkg::HASH_X)
             ^ 16'(coord.pixel_y * dvg_pkg::HASH_Y)
             ^ dvg_pkg::HASH_K;

        side_next.t_zero = !h_gt1;
        side_next.t_sat = h_gt1 && (YW'(coord.pixel_y) >= YW'(hdiv));
        side_next.q_zero = !w_gt1;
        side_next.q_sat = w_gt1 && (dx_abs >= span_d);
        side_next.noise = hash[15:8];
        side_next.bayer = {coord.pixel_y[1:0], coord.pixel_x[1:0]};
    end

    // divider chain: index 0 is the front register, STEPS is the last stage
    logic [HW-1:0]     rem_t [STEPS+1];
    logic [STEPS-1:0]  nq_t [STEPS+1];
    logic [WW-1:0]     rem_q [STEPS+1];
    logic [STEPS-1:0]  nq_q [STEPS+1];
    logic [HW-1:0]     rem_t0_reg;
    logic [STEPS-1:0]  nq_t0_reg;
    logic [WW-1:0]     rem_q0_reg;
    logic [STEPS-1:0]  nq_q0_reg;
    logic              pipe_valid_reg [STEPS+1];
    dvg_pkg::side_t    side_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // y below the divisor whenever the quotient is used
            rem_t0_reg <= HW'(coord.pixel_y);
            nq_t0_reg <= '0;
            rem_q0_reg <= num_q[PW-1:STEPS];
            nq_q0_reg <= num_q[STEPS-1:0];
            side_reg[0] <= side_next;
            for (int s = 1; s <= STEPS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STEPS; s++)
            begin
                pipe_valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            pipe_valid_reg[0] <= coord.valid;
            for (int s = 1; s <= STEPS; s++)
            begin
                pipe_valid_reg[s] <= pipe_valid_reg[s-1];
            end
        end
    end

    assign rem_t[0] = rem_t0_reg;
    assign nq_t[0] = nq_t0_reg;
    assign rem_q[0] = rem_q0_reg;
    assign nq_q[0] = nq_q0_reg;

    for (genvar gs = 0; gs < STEPS; gs++)
    begin : g_div
        // vertical blend weight y * 65536 / (height - 1)
        dvg_div_stage #(
            .RW (HW)
        ) u_div_t (
            .clk     (clk),
            .en      (adv),
            .divisor (hdiv),
            .rem_in  (rem_t[gs]),
            .nq_in   (nq_t[gs]),
            .rem_reg (rem_t[gs+1]),
            .nq_reg  (nq_t[gs+1])
        );

        // rounded vignette index, leading quotient bits come out zero
        dvg_div_stage #(
            .RW (WW)
        ) u_div_q (
            .clk     (clk),
            .en      (adv),
            .divisor (span),
            .rem_in  (rem_q[gs]),
            .nq_in   (nq_q[gs]),
            .rem_reg (rem_q[gs+1]),
            .nq_reg  (nq_q[gs+1])
        );
    end

    // select stage: apply saturation, look up dither and noise offsets
    dvg_pkg::side_t       side_end;
    logic [16:0]          t_next;
    logic [B-1:0]         q_next;
    logic [16:0]          t_reg;
    logic [B-1:0]         q_reg;
    logic signed [OW-1:0] off_rb_reg;
    logic signed [OW-1:0] off_g_reg;
    logic                 sel_valid_reg;

    assign side_end = side_reg[STEPS];

    always_comb
    begin
        priority if (side_end.t_zero) t_next = '0;
        else if (side_end.t_sat) t_next = 17'h10000;
        else t_next = {1'b0, nq_t[STEPS]};

        priority if (side_end.q_zero) q_next = '0;
        else if (side_end.q_sat) q_next = '1;
        else q_next = nq_q[STEPS][B-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= t_next;
            q_reg <= q_next;
            off_rb_reg <= dit_rb_rom[side_end.bayer] + noi_rb_rom[side_end.noise];
            off_g_reg <= dit_g_rom[side_end.bayer] + noi_g_rom[side_end.noise];
        end
    end

    // blend stage: vertical blend per channel, vignette table read
    logic [23:0]          blend_reg [3];
    logic [16:0]          vig_reg;
    logic signed [OW-1:0] off_rb_b_reg;
    logic signed [OW-1:0] off_g_b_reg;
    logic                 blend_valid_reg;
    logic [16:0]          t_inv;

    assign t_inv = 17'h10000 - t_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                blend_reg[c] <= 24'(top_reg[c]) * 24'(t_inv) + 24'(bot_reg[c]) * 24'(t_reg);
            end
            vig_reg <= vig_rom[q_reg];
            off_rb_b_reg <= off_rb_reg;
            off_g_b_reg <= off_g_reg;
        end
    end

    // scale stage: blend * vignette, back to q8.16
    logic [23:0]          scaled_reg [3];
    logic signed [OW-1:0] off_rb_s_reg;
    logic signed [OW-1:0] off_g_s_reg;
    logic                 scale_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                scaled_reg[c] <= 24'((41'(blend_reg[c]) * 41'(vig_reg)) >> 16);
            end
            off_rb_s_reg <= off_rb_b_reg;
            off_g_s_reg <= off_g_b_reg;
        end
    end

    // clamp stage: add offset, clip to 0..255, output register
    logic signed [25:0] chan_sum [3];
    logic [7:0]         level_next [3];
    logic [7:0]         level_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chan_sum[c] = $signed({2'b00, scaled_reg[c]})
                        + ($signed(26'(c == 1 ? off_g_s_reg : off_rb_s_reg)) <<< 8);
            if (chan_sum[c] < 0) level_next[c] = '0;
            else if (chan_sum[c][25:16] > 10'd255) level_next[c] = 8'hFF;
            else level_next[c] = chan_sum[c][23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                level_reg[c] <= level_next[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            blend_valid_reg <= 1'b0;
            scale_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sel_valid_reg <= pipe_valid_reg[STEPS];
            blend_valid_reg <= sel_valid_reg;
            scale_valid_reg <= blend_valid_reg;
            out_valid_reg <= scale_valid_reg;
        end
    end

    // result side
    assign color.valid = out_valid_reg;
    assign color.red_level = level_reg[0];
    assign color.green_level = level_reg[1];
    assign color.blue_level = level_reg[2];
    assign color.pixel_rgb565 = {level_reg[0][7:3], level_reg[1][7:2], level_reg[2][7:3]};

endmodule
